// File: rtl/b64se_pkg.sv
package b64se_pkg;

   // ascii codes used by the encoder
   localparam logic [6:0] CharUpperA = 7'd65;
   localparam logic [6:0] CharLowerA = 7'd97;
   localparam logic [6:0] CharZero   = 7'd48;
   localparam logic [6:0] CharPlus   = 7'd43;
   localparam logic [6:0] CharSlash  = 7'd47;
   localparam logic [6:0] CharPad    = 7'd61;

   // number of bytes already held when a group closes
   localparam logic [1:0] PhaseEmpty = 2'd0;
   localparam logic [1:0] PhaseOne   = 2'd1;
   localparam logic [1:0] PhaseTwo   = 2'd2;
   localparam logic [1:0] PhaseBad   = 2'd3;

   // character slot within one output group
   localparam logic [1:0] SlotFirst  = 2'd0;
   localparam logic [1:0] SlotSecond = 2'd1;
   localparam logic [1:0] SlotThird  = 2'd2;
   localparam logic [1:0] SlotFourth = 2'd3;

   localparam int QueueDepthDefault = 2;

   // one closed group handed from front to back
   typedef struct packed {
      logic [23:0] group;
      logic [1:0]  phase;
      logic        last;
   } entry_type;

   // six-bit value to its base64 character
   function automatic logic [6:0] sextet_char(input logic [5:0] s);
      logic [6:0] wide;
      wide = {1'b0, s};
      if (s < 6'd26) begin
         return CharUpperA + wide;
      end else if (s < 6'd52) begin
         return CharLowerA + wide - 7'd26;
      end else if (s < 6'd62) begin
         return CharZero + wide - 7'd52;
      end else if (s == 6'd62) begin
         return CharPlus;
      end else begin
         return CharSlash;
      end
   endfunction

endpackage

// File: rtl/b64se_front.sv
module b64se_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // end_of_message
   output logic                  push,
   output b64se_pkg::entry_type  push_entry,
   input  logic                  queue_full
);
   import b64se_pkg::*;

   logic [15:0] pending_ff, pending_in;
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  phase_eff;
   logic        accept;
   logic        closes;

   // take a byte whenever the queue has room for a closed group
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign phase_eff  = (phase_ff == PhaseBad) ? PhaseEmpty : phase_ff;
   assign closes     = req_tlast || (phase_eff == PhaseTwo);
   assign push       = accept && closes;

   // build the 24-bit group word
   always_comb begin
      push_entry.phase = phase_eff;
      push_entry.last  = req_tlast;
      case (phase_eff)
         PhaseEmpty: push_entry.group = {req_tdata, 16'd0};
         PhaseOne:   push_entry.group = {pending_ff[15:8], req_tdata, 8'd0};
         default:    push_entry.group = {pending_ff, req_tdata};
      endcase
   end

   // gather state update
   always_comb begin
      pending_in = pending_ff;
      phase_in   = phase_ff;
      if (accept) begin
         if (closes) begin
            pending_in = 16'd0;
            phase_in   = PhaseEmpty;
         end else if (phase_eff == PhaseEmpty) begin
            pending_in = {req_tdata, 8'd0};
            phase_in   = PhaseOne;
         end else begin
            pending_in = {pending_ff[15:8], req_tdata};
            phase_in   = PhaseTwo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 16'd0;
         phase_ff   <= PhaseEmpty;
      end else begin
         pending_ff <= pending_in;
         phase_ff   <= phase_in;
      end
   end

   // the gather phase never reaches the unused code
   assert property (@(posedge clock) disable iff (reset) phase_ff != PhaseBad)
      else $error("front phase reached unused code");
   // a group of three always closes
   assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PhaseTwo) |-> push)
      else $error("third byte did not close group");

endmodule

// File: rtl/b64se_queue.sv
module b64se_queue #(
   parameter int Depth = b64se_pkg::QueueDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64se_pkg::entry_type  push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output b64se_pkg::entry_type  head_entry
);
   import b64se_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   entry_type           mem [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign full       = (count_ff == FullCnt);
   assign not_empty  = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("queue underflow");
   assert property (@(posedge clock) disable iff (reset) count_ff <= FullCnt)
      else $error("queue count out of range");

endmodule

// File: rtl/b64se_back.sv
module b64se_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  entry_valid,
   input  b64se_pkg::entry_type  entry,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [6:0] code_char, [7] zero
   output logic                  rsp_tlast    // last_char
);
   import b64se_pkg::*;

   entry_type   cur_ff, cur_in;
   logic        have_ff, have_in;
   logic [1:0]  slot_ff, slot_in;
   logic        out_valid_ff, out_valid_in;
   logic [6:0]  out_char_ff, out_char_in;
   logic        out_last_ff, out_last_in;
   logic        advance;
   logic        group_done;
   logic [5:0]  sextet;
   logic        is_pad;

   assign advance    = !out_valid_ff || rsp_tready;
   assign group_done = advance && have_ff && (slot_ff == SlotFourth);
   assign pop        = entry_valid && (!have_ff || group_done);

   // pick the sextet for the current slot
   always_comb begin
      case (slot_ff)
         SlotFirst:  sextet = cur_ff.group[23:18];
         SlotSecond: sextet = cur_ff.group[17:12];
         SlotThird:  sextet = cur_ff.group[11:6];
         default:    sextet = cur_ff.group[5:0];
      endcase
      is_pad = ((slot_ff == SlotThird) && (cur_ff.phase == PhaseEmpty))
            || ((slot_ff == SlotFourth) && (cur_ff.phase != PhaseTwo));
   end

   // group holder and character slot
   always_comb begin
      cur_in  = cur_ff;
      have_in = have_ff;
      slot_in = slot_ff;
      if (advance && have_ff) begin
         slot_in = slot_ff + 1'b1;
      end
      if (group_done) begin
         have_in = 1'b0;
      end
      if (pop) begin
         cur_in  = entry;
         have_in = 1'b1;
         slot_in = SlotFirst;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = have_ff;
         out_char_in  = is_pad ? CharPad : sextet_char(sextet);
         out_last_in  = (slot_ff == SlotFourth) && cur_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         slot_ff      <= SlotFirst;
         out_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tlast  = out_last_ff;

   // an idle holder always waits at the first slot
   assert property (@(posedge clock) disable iff (reset) !have_ff |-> slot_ff == SlotFirst)
      else $error("idle back end left mid group");
   // a new group is only taken when the previous one is finished
   assert property (@(posedge clock) disable iff (reset)
      pop && have_ff |-> slot_ff == SlotFourth && advance)
      else $error("group replaced before all characters left");

endmodule

// File: rtl/base64_stream_encoder.sv
// base64 encoder, one raw byte in per request, one ascii character out per request
// path: closing byte -> group queue -> group holder -> output register
// throughput: bytes taken 1 per cycle while the group queue has room; each group
// leaves as 4 characters at 1 per cycle while the receiver holds rsp_tready high
// reset: synchronous, clears the gather state, the group queue and the output stage
module base64_stream_encoder #(
   parameter int QueueDepth = b64se_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [6:0] code_char, [7] zero
   output logic       rsp_tlast     // last_char
);
   import b64se_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   logic      not_empty;
   entry_type head_entry;

   // front: gather bytes into groups
   b64se_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // queue of closed groups
   b64se_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head_entry (head_entry)
   );

   // back: emit four characters per group
   b64se_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (not_empty),
      .entry       (head_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// File: test/tb_base64_stream_encoder.sv
`timescale 1ns / 1ps

module tb_base64_stream_encoder;
   import b64se_pkg::*;

   // one encoded character as it should leave the block
   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } b64_char_type;

   // the 64 characters, index 0 in the top byte
   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int DRAIN_LIMIT = 5000;
   localparam int TAIL_CYCLES = 8;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] data_byte
   logic       req_tlast;    // end_of_message
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;    // [6:0] code_char, [7] zero
   logic       rsp_tlast;    // last_char

   // predictor state
   logic [15:0]  held_bytes = '0;
   logic [1:0]   held_phase = PhaseEmpty;
   b64_char_type expected_chars[$];
   b64_char_type oldest_char;

   int errors        = 0;
   int bytes_taken   = 0;
   int messages_done = 0;
   int chars_checked = 0;

   // idling controls
   bit tx_idle_on = 1'b0;
   bit rx_idle_on = 1'b0;
   bit long_hold  = 1'b0;
   int rx_gap     = 0;

   base64_stream_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [6:0] b64_letter(input logic [5:0] idx);
      logic [7:0] ch;
      ch = ALPHABET[8*(63 - idx) +: 8];
      return ch[6:0];
   endfunction

   // gather one byte; a closing byte yields four characters
   function automatic void encode_byte(input logic [7:0] b, input logic eom);
      logic [23:0]  word;
      logic [1:0]   ph;
      b64_char_type c;
      ph = (held_phase == PhaseBad) ? PhaseEmpty : held_phase;
      if (!eom && ph == PhaseEmpty) begin
         held_bytes = {b, 8'h00};
         held_phase = PhaseOne;
         return;
      end
      if (!eom && ph == PhaseOne) begin
         held_bytes[7:0] = b;
         held_phase = PhaseTwo;
         return;
      end
      case (ph)
         PhaseEmpty: word = {b, 16'h0000};
         PhaseOne:   word = {held_bytes[15:8], b, 8'h00};
         default:    word = {held_bytes, b};
      endcase
      c.last = 1'b0;
      c.code = b64_letter(word[23:18]);
      expected_chars.insert(expected_chars.size(), c);
      c.code = b64_letter(word[17:12]);
      expected_chars.insert(expected_chars.size(), c);
      c.code = (ph == PhaseEmpty) ? CharPad : b64_letter(word[11:6]);
      expected_chars.insert(expected_chars.size(), c);
      c.code = (ph == PhaseTwo) ? b64_letter(word[5:0]) : CharPad;
      c.last = eom;
      expected_chars.insert(expected_chars.size(), c);
      held_bytes = '0;
      held_phase = PhaseEmpty;
   endfunction

   // predict on accepted requests, compare accepted characters
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            encode_byte(req_tdata, req_tlast);
            bytes_taken++;
            if (req_tlast) messages_done++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               errors++;
               $display("%t: unexpected character, expected none, actual data 0x%02h last %0b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               oldest_char = expected_chars.pop_front();
               chars_checked++;
               if (rsp_tdata[6:0] !== oldest_char.code) begin
                  errors++;
                  $display("%t: code_char mismatch, expected 0x%02h, actual 0x%02h",
                           $time, oldest_char.code, rsp_tdata[6:0]);
               end
               if (rsp_tdata[7] !== 1'b0) begin
                  errors++;
                  $display("%t: fill bit mismatch, expected 0, actual %b", $time, rsp_tdata[7]);
               end
               if (rsp_tlast !== oldest_char.last) begin
                  errors++;
                  $display("%t: last_char mismatch, expected %0b, actual %b",
                           $time, oldest_char.last, rsp_tlast);
               end
            end
         end
      end
   end

   // receiver: random stall bursts, or a long hold
   always @(posedge clock) begin
      if (long_hold) begin
         rsp_tready <= 1'b0;
      end else if (rx_gap > 0) begin
         rsp_tready <= 1'b0;
         rx_gap <= rx_gap - 1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rx_gap <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // offer one byte and wait for its request to be taken
   task automatic send_byte(input logic [7:0] b, input logic eom);
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eom;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // hold off until every predicted character has left
   task automatic wait_results_out();
      int n;
      n = 0;
      @(posedge clock);
      while (expected_chars.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
   endtask

   // known messages, padding cases and alphabet extremes
   task automatic test_directed();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      // full group closing the message
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      // one byte over: two pads
      send_byte(8'h4D, 1'b1);
      // two bytes over: one pad
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b1);
      // all zeros then all ones
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // plus signs only
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      // extremes alone and padded
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // random messages with random idling on both sides
   task automatic test_random_messages(input int byte_budget);
      int sent;
      int len;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      sent = 0;
      while (sent < byte_budget) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
         send_message(len);
         sent += len;
      end
   endtask

   // output held off while input keeps coming, then a full pause
   task automatic test_backpressure();
      tx_idle_on = 1'b0;
      fork
         begin
            long_hold <= 1'b1;
            repeat (60) @(posedge clock);
            long_hold <= 1'b0;
         end
      join_none
      send_message(7);
      send_message(9);
      req_tvalid <= 1'b0;
      wait_results_out();
      send_message(5);
   endtask

   // closing stretch at full rate
   task automatic test_full_rate();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      send_message(3);
      send_message(12);
      send_message(1);
      send_message(14);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_messages(125);
      test_backpressure();
      test_random_messages(10);
      test_full_rate();

      req_tvalid <= 1'b0;
      wait_results_out();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         errors += expected_chars.size();
         $display("%t: %0d characters never arrived", $time, expected_chars.size());
      end

      $display("run covered %0d bytes in %0d messages, %0d characters checked",
               bytes_taken, messages_done, chars_checked);
      $display("with random stalls, a long output hold and a full-rate closing stretch");
      if (errors == 0) begin
         $display("tb_base64_stream_encoder: PASS");
      end else begin
         $display("tb_base64_stream_encoder: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200000;
      $display("tb_base64_stream_encoder: FAIL");
      $finish;
   end

endmodule
